// ===== rtl/ddpo_pkg.sv =====
// Package: shared types and constants for the differential drive odometry block.
`timescale 1ns / 1ps
`default_nettype none
package ddpo_pkg;
    typedef enum logic [1:0] {
        KIND_TWIST  = 2'd0,
        KIND_EDGE   = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIN,
        ST_ANG,
        ST_DONE
    } state_t;

    localparam logic [0:0] REG_WHEEL_DISTANCE  = 1'd0;
    localparam logic [0:0] REG_TICKS_PER_METER = 1'd1;

    localparam int NUM_W = 64;
    localparam int DEN_W = 48;
    localparam logic [27:0] VEL_SCALE = 28'd128000000;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/ddpo_divider.sv =====
// Restoring divider: one quotient bit per cycle, signed result saturated to Q8.8.
`timescale 1ns / 1ps
`default_nettype none
module ddpo_divider
    import ddpo_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic                     num_neg,
    input  wire logic [NUM_W-1:0]         num_mag,
    input  wire logic [DEN_W-1:0]         den,
    output div_ctl_t                      ctl,
    output logic signed [15:0]            result
);
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial     = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = num_mag;
            rem_next  = '0;
            cnt_next  = 7'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DEN_W]) begin
                rem_next = diff;
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
            neg_reg <= num_neg;
        end
    end

    always_comb begin
        if (neg_reg) begin
            result = (quo_reg > 64'd32768) ? -16'sd32768 : 16'(-quo_reg);
        end else begin
            result = (quo_reg > 64'd32767) ? 16'sd32767 : 16'(quo_reg);
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_cnt_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !start |=> cnt_reg == $past(cnt_reg)) else $error("counter moved");
endmodule
`default_nettype wire

// ===== rtl/differential_drive_pwm_odometry.sv =====
// Top level: twist to duty, quadrature counting and tick velocity reports.
// Usage:
//  - s_ channel carries one request of kind twist, encoder edge, tick or status.
//  - m_ channel returns exactly one result per request: the applied duties and,
//    for a tick with history, the counts and Q8.8 linear/angular velocity.
//  - cfg channel writes wheel_distance (index 0) or ticks_per_meter (index 1);
//    write only while idle.
// Flow: twist, edge, status and a tick without report put the result on m_
//  the cycle after acceptance. A tick that reports runs two serial 64-bit
//  divisions on one shared divider, one quotient bit per cycle, in ST_LIN
//  and ST_ANG; ST_DONE then registers the result on m_. s_ready is low from
//  acceptance until the result is taken; one request at a time.
// Reset: aresetn synchronous low clears speeds, counts, history and config to
//  defaults (wheel_distance 77, ticks_per_meter 1000).
// Stall: the result stays in the output register until m_ready; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module differential_drive_pwm_odometry
    import ddpo_pkg::*;
#(
    parameter int DUTY_FULL_SCALE = 16380
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [15:0] s_linear_speed,
    input  wire logic signed [15:0] s_angular_speed,
    input  wire logic               s_encoder_side,
    input  wire logic               s_phase_b_level,
    input  wire logic [31:0]        s_now_us,
    input  wire logic               s_emergency_latched,
    input  wire logic               s_emergency_active,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [13:0]             m_left_forward_duty,
    output logic [13:0]             m_left_reverse_duty,
    output logic [13:0]             m_right_forward_duty,
    output logic [13:0]             m_right_reverse_duty,
    output logic                    m_report_valid,
    output logic signed [15:0]      m_linear_velocity,
    output logic signed [15:0]      m_angular_velocity,
    output logic [31:0]             m_left_count,
    output logic [31:0]             m_right_count
);
    localparam int FS_W = $clog2(DUTY_FULL_SCALE + 1);

    state_t state_reg, state_next;
    logic [15:0] wd_reg, tpm_reg;
    logic signed [13:0] lt_reg, rt_reg, la_reg, ra_reg;
    logic        applied_reg, hist_reg;
    logic [31:0] lc_reg, rc_reg, plc_reg, prc_reg, ptime_reg;

    // captured tick operands
    logic signed [33:0] sum_d_reg, dif_d_reg;
    logic [DEN_W-1:0]   den_reg;
    logic signed [15:0] lin_reg;

    // divider hookup
    logic               div_start;
    logic               div_neg;
    logic [NUM_W-1:0]   div_mag;
    div_ctl_t           div_ctl;
    logic signed [15:0] div_q;

    // twist arithmetic in 2^-21 units
    logic signed [37:0] lin_s, turn, lv, rv;
    logic signed [13:0] lspd, rspd;

    function automatic logic signed [13:0] to_speed(input logic signed [37:0] v);
        logic signed [37:0] q;
        begin
            q = v / 38'sd512;
            if (v >= 38'sd2097152) to_speed = 14'sd4096;
            else if (v <= -38'sd2097152) to_speed = -14'sd4096;
            else to_speed = 14'(q);
        end
    endfunction

    function automatic logic [13:0] duty(input logic signed [13:0] s);
        logic [FS_W+13:0] p;
        begin
            p = (FS_W+14)'($unsigned(FS_W'(DUTY_FULL_SCALE))) * (FS_W+14)'($unsigned(s));
            duty = 14'(p >> 12);
        end
    endfunction

    always_comb begin
        lin_s = 38'(s_linear_speed) <<< 9;
        turn  = $signed({22'd0, wd_reg}) * 38'(s_angular_speed);
        lv    = lin_s - turn;
        rv    = -(lin_s + turn);
        lspd  = to_speed(lv);
        rspd  = to_speed(rv);
    end

    // numerator magnitude: |d| * 128e6, d up to 2^33
    logic signed [33:0] d_sel;
    logic [33:0]        d_abs;
    always_comb begin
        d_sel   = (state_reg == ST_LIN) ? dif_d_reg : -sum_d_reg;
        d_abs   = d_sel[33] ? 34'(-d_sel) : d_sel;
        div_neg = d_sel[33];
        div_mag = 64'(d_abs) * 64'(VEL_SCALE);
    end

    ddpo_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_neg (div_neg),
        .num_mag (div_mag),
        .den     (den_reg),
        .ctl     (div_ctl),
        .result  (div_q)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid;

    logic s_fire;
    assign s_fire = s_valid && s_ready;
    logic [31:0] dt;
    assign dt = s_now_us - ptime_reg;
    logic [31:0] dl, dr;
    assign dl = lc_reg - plc_reg;
    assign dr = rc_reg - prc_reg;

    logic started_reg;

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: if (s_fire && s_kind == KIND_TICK && hist_reg && dt != 32'd0
                         && tpm_reg != 16'd0) state_next = ST_LIN;
            ST_LIN: begin
                div_start = !started_reg;
                if (div_ctl.done) state_next = ST_ANG;
            end
            ST_ANG: begin
                div_start = !started_reg;
                if (div_ctl.done) state_next = ST_DONE;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            wd_reg      <= 16'd77;
            tpm_reg     <= 16'd1000;
            lt_reg <= '0; rt_reg <= '0; la_reg <= '0; ra_reg <= '0;
            applied_reg <= 1'b0;
            hist_reg    <= 1'b0;
            lc_reg <= '0; rc_reg <= '0; plc_reg <= '0; prc_reg <= '0;
            ptime_reg   <= '0;
            m_valid     <= 1'b0;
            m_report_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (div_start) started_reg <= 1'b1;
            else if (div_ctl.done) started_reg <= 1'b0;
            if (cfg_valid) begin
                if (cfg_index == REG_WHEEL_DISTANCE) wd_reg <= cfg_data;
                else tpm_reg <= cfg_data;
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (s_fire) begin
                case (kind_t'(s_kind))
                    KIND_TWIST: begin
                        lt_reg <= lspd; rt_reg <= rspd;
                        if (!applied_reg) begin
                            la_reg <= lspd; ra_reg <= rspd; applied_reg <= 1'b1;
                        end
                    end
                    KIND_EDGE: begin
                        if (s_encoder_side) rc_reg <= s_phase_b_level ? rc_reg + 1 : rc_reg - 1;
                        else lc_reg <= s_phase_b_level ? lc_reg + 1 : lc_reg - 1;
                    end
                    KIND_TICK: begin
                        if (!applied_reg) begin la_reg <= lt_reg; ra_reg <= rt_reg; end
                        applied_reg <= 1'b0;
                        hist_reg  <= 1'b1;
                        plc_reg   <= lc_reg;
                        prc_reg   <= rc_reg;
                        ptime_reg <= s_now_us;
                    end
                    KIND_STATUS: begin
                        if (s_emergency_latched || s_emergency_active) begin
                            lt_reg <= '0; rt_reg <= '0; la_reg <= '0; ra_reg <= '0;
                            applied_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
                m_report_valid <= 1'b0;
                if (state_next != ST_LIN) m_valid <= 1'b1;
            end
            if (state_reg == ST_DONE) begin
                m_valid <= 1'b1;
                m_report_valid <= 1'b1;
            end
        end
        if (s_fire) begin
            dif_d_reg <= 34'($signed(dl)) - 34'($signed(dr));
            sum_d_reg <= 34'($signed(dl)) + 34'($signed(dr));
            den_reg   <= 48'(dt) * 48'(tpm_reg);
            m_left_count  <= '0;
            m_right_count <= '0;
            m_linear_velocity  <= '0;
            m_angular_velocity <= '0;
        end
        if (state_reg == ST_LIN && div_ctl.done) lin_reg <= div_q;
        // counts cannot move while dividing: input is held off
        if (state_reg == ST_DONE) begin
            m_linear_velocity  <= lin_reg;
            m_angular_velocity <= div_q;
            m_left_count  <= lc_reg;
            m_right_count <= rc_reg;
        end
    end

    // results read applied speeds
    always_comb begin
        m_left_forward_duty  = (la_reg > 0) ? duty(la_reg) : 14'd0;
        m_left_reverse_duty  = (la_reg > 0) ? 14'd0 : duty(-la_reg);
        m_right_forward_duty = (ra_reg > 0) ? duty(ra_reg) : 14'd0;
        m_right_reverse_duty = (ra_reg > 0) ? 14'd0 : duty(-ra_reg);
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready) else $error("ready while dividing");
    a_report_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_report_valid) |-> $past(state_reg) == ST_DONE) else $error("stray report");
    a_one_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_left_forward_duty != 0 && m_left_reverse_duty != 0)) else $error("both channels");
endmodule
`default_nettype wire
